// ----- hdl/line_sensor_position_drive_assert.svh -----
// Assertion macros for the line sensor position and drive block.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef LINE_SENSOR_POSITION_DRIVE_ASSERT_SVH
`define LINE_SENSOR_POSITION_DRIVE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSPD_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSPD_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lspd_pkg.sv -----
// Shared constants, types and weight table for the line sensor position drive.
// No dependencies; imported by the divider, the top level and the testbench.
`timescale 1ns / 1ps

package lspd_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_W       = 3;
    localparam int DIV_W      = 29;
    localparam int DVS_W      = 12;
    localparam int DCNT_W     = $clog2(DIV_W + 1);
    localparam int POS_W      = 25;
    localparam int CNT_W      = 4;
    localparam int PWM_W      = 16;
    localparam int CRUISE_W   = 16;
    localparam int THR_W      = 7;
    localparam int GAIN_W     = 7;
    localparam int WGT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_W      = ((POS_W + CNT_W + 2 * PWM_W + 1 + 7) / 8) * 8;

    localparam int NORM_SCALE = 100;
    localparam int PCT_DIV    = 100;
    localparam int PWM_MAX    = 65535;
    localparam int PWM_CLAMP  = (PWM_MAX + 1) * PCT_DIV;

    // divide by PCT_DIV as a multiply by a rounded-up reciprocal, exact below 2^PDIV_W
    localparam int PDIV_W     = 23;
    localparam int RCP_W      = 24;
    localparam int PCT_SHIFT  = 30;
    localparam int PCT_RECIP  = ((1 << PCT_SHIFT) + PCT_DIV - 1) / PCT_DIV;
    localparam int PCT_PROD_W = PDIV_W + RCP_W;
    localparam int PCT_Q_W    = PCT_PROD_W - PCT_SHIFT;

    localparam logic [CRUISE_W-1:0] CRUISE_RST = 16'd4000;
    localparam logic [THR_W-1:0]    THR_RST    = 7'd60;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 7'd18;

    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;

    localparam logic MODE_CAL   = 1'b0;
    localparam logic MODE_TRACK = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic signed [WGT_W-1:0] f_weight(input logic [CH_W-1:0] ch);
        logic signed [WGT_W-1:0] w;
        case (ch)
            3'd0: w = 8'sd90;
            3'd1: w = 8'sd75;
            3'd2: w = 8'sd40;
            3'd3: w = 8'sd10;
            3'd4: w = -8'sd10;
            3'd5: w = -8'sd40;
            3'd6: w = -8'sd75;
            default: w = -8'sd90;
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/lspd_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lspd_pkg for operand widths and the request/response structs.
`timescale 1ns / 1ps

module lspd_div import lspd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    trial;

    assign shifted = {r_rem, r_quo[DIV_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!trial[DVS_W]) begin
                r_rem <= trial[DVS_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DVS_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- hdl/line_sensor_position_drive.sv -----
// Flow: a calibrate request goes from acceptance straight to the output state; a track request
// runs up to nine divider passes (eight channel normalisations and the position average) and,
// when the position is nonzero, two PWM scalings; the output state waits while the output stalls.
// Throughput: one request at a time; the next is taken the cycle after the result is registered.
// Reset: synchronous, active low; spans, held PWM values and settings return to reset values.
// Depends on lspd_pkg, lspd_div and line_sensor_position_drive_assert.svh.
`timescale 1ns / 1ps

`include "line_sensor_position_drive_assert.svh"

module line_sensor_position_drive import lspd_pkg::*; #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample_0 .. sample_7, SAMPLE_BITS each, sample_0 lowest, zero padded
    input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // position[24:0], sensed_count[28:25], left_pwm[44:29], right_pwm[60:45],
    // drive_updated[61], zero padded
    output logic [OUT_W-1:0]      m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int NDIV_W = SB + 7;
    localparam int NORM_W = SB + 8;
    localparam int PROD_W = NORM_W + WGT_W;
    localparam int SUM_W  = PROD_W + $clog2(CHANNELS);
    localparam int SPD_W  = SUM_W + 1;
    localparam int MUL_W  = SPD_W + GAIN_W;
    localparam int PAD_W  = OUT_W - (POS_W + CNT_W + 2 * PWM_W + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NLOAD = 4'd1;
    localparam logic [3:0] ST_NWAIT = 4'd2;
    localparam logic [3:0] ST_NACC  = 4'd3;
    localparam logic [3:0] ST_PLOAD = 4'd4;
    localparam logic [3:0] ST_PWAIT = 4'd5;
    localparam logic [3:0] ST_SPEED = 4'd6;
    localparam logic [3:0] ST_SMUL  = 4'd7;
    localparam logic [3:0] ST_SWAIT = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]              r_state;
    logic [3:0]              n_state;
    logic [CRUISE_W-1:0]     r_cruise;
    logic [THR_W-1:0]        r_thr;
    logic [GAIN_W-1:0]       r_gain;
    logic [SB-1:0]           r_max [CHANNELS];
    logic [SB-1:0]           r_min [CHANNELS];
    logic [SB-1:0]           r_smp [CHANNELS];
    logic [CH_W-1:0]         r_ch;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_side;
    logic                    r_upd;
    logic                    r_mvalid;
    logic [PWM_W-1:0]        r_held_left;
    logic [PWM_W-1:0]        r_held_right;
    logic [PWM_W-1:0]        r_new_left;
    logic [PWM_W-1:0]        r_new_right;
    logic signed [NORM_W-1:0] r_norm;
    logic                    r_neg;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] r_pos;
    logic [SPD_W-1:0]        r_mag;
    logic [PDIV_W-1:0]       r_pdiv;
    logic [POS_W-1:0]        r_out_pos;
    logic [CNT_W-1:0]        r_out_cnt;
    logic [PWM_W-1:0]        r_out_left;
    logic [PWM_W-1:0]        r_out_right;
    logic                    r_out_upd;

    t_div_req                div_req;
    t_div_rsp                div_rsp;

    logic                    accept;
    logic                    out_free;
    logic                    last_ch;
    logic [SB-1:0]           cur_mx;
    logic [SB-1:0]           cur_mn;
    logic [SB-1:0]           cur_smp;
    logic                    span_ok;
    logic [SB-1:0]           span;
    logic signed [SB:0]      diff;
    logic [SB-1:0]           diff_mag;
    logic [NDIV_W-1:0]       norm_dividend;
    logic [NORM_W-1:0]       norm_q;
    logic signed [NORM_W-1:0] thr_s;
    logic                    sensed;
    logic signed [PROD_W-1:0] wprod;
    logic [SUM_W-1:0]        sum_mag;
    logic [SUM_W-1:0]        pos_q;
    logic signed [SPD_W-1:0] cruise_s;
    logic signed [SPD_W-1:0] pos_s;
    logic signed [SPD_W-1:0] speed;
    logic [SPD_W-1:0]        speed_mag;
    logic [MUL_W-1:0]        pwm_prod;
    logic [PDIV_W-1:0]       pwm_dividend;
    logic [PCT_PROD_W-1:0]   pct_prod;
    logic [PCT_Q_W-1:0]      pct_q;
    logic [PWM_W-1:0]        pwm_q;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_mvalid || m_axis_tready;
    assign last_ch       = (r_ch == CH_W'(CHANNELS - 1));

    assign cur_mx   = r_max[r_ch];
    assign cur_mn   = r_min[r_ch];
    assign cur_smp  = r_smp[r_ch];
    assign span_ok  = (cur_mx > cur_mn);
    assign span     = cur_mx - cur_mn;
    assign diff     = $signed({1'b0, cur_mx}) - $signed({1'b0, cur_smp});
    assign diff_mag = diff[SB] ? SB'(-diff) : SB'(diff);
    assign norm_dividend = NDIV_W'(diff_mag) * NDIV_W'(NORM_SCALE);
    assign norm_q   = NORM_W'(div_rsp.quotient);

    assign thr_s    = $signed(NORM_W'(r_thr));
    assign sensed   = (r_norm >= thr_s);
    assign wprod    = PROD_W'(r_norm) * PROD_W'(f_weight(r_ch));

    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign pos_q    = SUM_W'(div_rsp.quotient);

    assign cruise_s  = $signed(SPD_W'(r_cruise));
    assign pos_s     = SPD_W'(r_pos);
    assign speed     = r_side ? (cruise_s + pos_s) : (cruise_s - pos_s);
    assign speed_mag = speed[SPD_W-1] ? SPD_W'(-speed) : SPD_W'(speed);

    assign pwm_prod     = MUL_W'(r_mag) * MUL_W'(r_gain);
    assign pwm_dividend = (pwm_prod >= MUL_W'(PWM_CLAMP)) ? PDIV_W'(PWM_CLAMP)
                                                           : PDIV_W'(pwm_prod);
    assign pct_prod     = PCT_PROD_W'(r_pdiv) * PCT_PROD_W'(PCT_RECIP);
    assign pct_q        = pct_prod[PCT_PROD_W-1:PCT_SHIFT];
    assign pwm_q        = (pct_q > PCT_Q_W'(PWM_MAX)) ? PWM_W'(PWM_MAX)
                                                      : pct_q[PWM_W-1:0];

    always_comb begin
        div_req = '0;
        case (r_state)
            ST_NLOAD: begin
                div_req.start    = span_ok;
                div_req.dividend = DIV_W'(norm_dividend);
                div_req.divisor  = DVS_W'(span);
            end
            ST_PLOAD: begin
                div_req.start    = (r_cnt != '0);
                div_req.dividend = DIV_W'(sum_mag);
                div_req.divisor  = DVS_W'(r_cnt);
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    lspd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (s_axis_tuser == MODE_TRACK) ? ST_NLOAD : ST_OUT;
                end
            end
            ST_NLOAD: n_state = span_ok ? ST_NWAIT : ST_NACC;
            ST_NWAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_NACC;
                end
            end
            ST_NACC:  n_state = last_ch ? ST_PLOAD : ST_NLOAD;
            ST_PLOAD: n_state = (r_cnt == '0) ? ST_OUT : ST_PWAIT;
            ST_PWAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_SPEED;
                end
            end
            ST_SPEED: n_state = (r_pos == '0) ? ST_OUT : ST_SMUL;
            ST_SMUL:  n_state = ST_SWAIT;
            ST_SWAIT: n_state = r_side ? ST_OUT : ST_SPEED;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cruise     <= CRUISE_RST;
            r_thr        <= THR_RST;
            r_gain       <= GAIN_RST;
            r_ch         <= '0;
            r_cnt        <= '0;
            r_side       <= 1'b0;
            r_upd        <= 1'b0;
            r_mvalid     <= 1'b0;
            r_held_left  <= '0;
            r_held_right <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_max[c] <= '0;
                r_min[c] <= '1;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CRUISE: r_cruise <= i_cfg_data[CRUISE_W-1:0];
                    CFG_THRESH: r_thr    <= i_cfg_data[THR_W-1:0];
                    CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_ch   <= '0;
                        r_cnt  <= '0;
                        r_side <= 1'b0;
                        r_upd  <= 1'b0;
                        if (s_axis_tuser == MODE_CAL) begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                if (r_max[c] < s_axis_tdata[c*SB +: SB]) begin
                                    r_max[c] <= s_axis_tdata[c*SB +: SB];
                                end
                                if (r_min[c] > s_axis_tdata[c*SB +: SB]) begin
                                    r_min[c] <= s_axis_tdata[c*SB +: SB];
                                end
                            end
                        end
                    end
                end
                ST_NACC: begin
                    if (sensed) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (!last_ch) begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                ST_SWAIT: begin
                    r_side <= 1'b1;
                    if (r_side) begin
                        r_upd <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free && r_upd) begin
                        r_held_left  <= r_new_left;
                        r_held_right <= r_new_right;
                    end
                end
                default: ;
            endcase
            if (r_state == ST_OUT && out_free) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_sum <= '0;
                r_pos <= '0;
                if (accept) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        r_smp[c] <= s_axis_tdata[c*SB +: SB];
                    end
                end
            end
            ST_NLOAD: begin
                r_neg  <= diff[SB];
                r_norm <= '0;
            end
            ST_NWAIT: begin
                if (div_rsp.done) begin
                    r_norm <= r_neg ? $signed(-norm_q) : $signed(norm_q);
                end
            end
            ST_NACC: begin
                if (sensed) begin
                    r_sum <= r_sum + SUM_W'(wprod);
                end
            end
            ST_PLOAD: begin
                r_neg <= r_sum[SUM_W-1];
            end
            ST_PWAIT: begin
                if (div_rsp.done) begin
                    r_pos <= r_neg ? $signed(-pos_q) : $signed(pos_q);
                end
            end
            ST_SPEED: begin
                r_mag <= speed_mag;
            end
            ST_SMUL: begin
                r_pdiv <= pwm_dividend;
            end
            ST_SWAIT: begin
                if (r_side) begin
                    r_new_right <= pwm_q;
                end else begin
                    r_new_left <= pwm_q;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_pos   <= POS_W'(r_pos);
                    r_out_cnt   <= r_cnt;
                    r_out_left  <= r_upd ? r_new_left : r_held_left;
                    r_out_right <= r_upd ? r_new_right : r_held_right;
                    r_out_upd   <= r_upd;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {PAD_W'(0), r_out_upd, r_out_right, r_out_left,
                            r_out_cnt, r_out_pos};

    `LSPD_AST_IMP(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `LSPD_AST_IMP(a_upd_has_pos, i_clk, i_rst_n, r_state == ST_OUT && r_upd, r_pos != '0, "drive update with zero position")
    `LSPD_AST_IMP(a_no_count_no_pos, i_clk, i_rst_n, r_state == ST_OUT && r_cnt == '0, r_pos == '0, "position without sensed channels")
    `LSPD_AST_NXT(a_held_stable, i_clk, i_rst_n, !(r_state == ST_OUT && r_upd), $stable(r_held_left) && $stable(r_held_right), "held PWM changed without update")

endmodule

// ----- tb/tb_line_sensor_position_drive.sv -----
// Self-checking testbench for line_sensor_position_drive: calibration spans, track-mode
// normalisation, weighted line position and PWM drive, checked against a local predictor.
// Depends on lspd_pkg and the line_sensor_position_drive RTL.
`timescale 1ns / 1ps

module tb_line_sensor_position_drive;
    import lspd_pkg::*;

    localparam int SMP_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef logic [CHANNELS*SMP_W-1:0] t_frame;

    typedef struct packed {
        logic                     updated;
        logic [PWM_W-1:0]         right_pwm;
        logic [PWM_W-1:0]         left_pwm;
        logic [CNT_W-1:0]         count;
        logic signed [POS_W-1:0]  position;
    } t_drive_result;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    // sample_0 .. sample_7, SMP_W each, sample_0 lowest
    t_frame                s_axis_tdata  = '0;
    // mode
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // position, sensed_count, left_pwm, right_pwm, drive_updated, zero padded
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic [CRUISE_W-1:0] cruise_reg;
    logic [THR_W-1:0]    thresh_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [SMP_W-1:0]    cal_max [CHANNELS];
    logic [SMP_W-1:0]    cal_min [CHANNELS];
    logic [PWM_W-1:0]    held_left;
    logic [PWM_W-1:0]    held_right;

    t_drive_result drive_expected [$];

    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int rx_hold_cycles = 0;
    int mismatches = 0;
    int frames_sent = 0;
    int track_frames = 0;
    int drive_updates = 0;
    int settings_used = 0;

    line_sensor_position_drive uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint lane_weight(input int c);
        case (c)
            0: return 90;
            1: return 75;
            2: return 40;
            3: return 10;
            4: return -10;
            5: return -40;
            6: return -75;
            default: return -90;
        endcase
    endfunction

    function automatic logic [PWM_W-1:0] speed_pwm(input longint speed);
        longint mag;
        longint v;
        mag = (speed < 0) ? -speed : speed;
        v = (mag * longint'(gain_reg)) / 100;
        return (v > 65535) ? 16'hFFFF : v[PWM_W-1:0];
    endfunction

    function automatic t_drive_result predict_drive(input logic mode, input t_frame frame);
        t_drive_result r;
        longint smp, mx, mn, norm, sum, cnt, pos, thr;
        r = '0;
        if (mode == MODE_CAL) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (cal_max[c] < frame[c*SMP_W +: SMP_W]) cal_max[c] = frame[c*SMP_W +: SMP_W];
                if (cal_min[c] > frame[c*SMP_W +: SMP_W]) cal_min[c] = frame[c*SMP_W +: SMP_W];
            end
        end else begin
            sum = 0;
            cnt = 0;
            thr = longint'(thresh_reg);
            for (int c = 0; c < CHANNELS; c++) begin
                smp = longint'(frame[c*SMP_W +: SMP_W]);
                mx = longint'(cal_max[c]);
                mn = longint'(cal_min[c]);
                norm = 0;
                if (mx > mn) norm = (100 * (mx - smp)) / (mx - mn);
                if (norm >= thr) begin
                    cnt++;
                    sum += norm * lane_weight(c);
                end
            end
            pos = (cnt != 0) ? sum / cnt : 0;
            if (pos != 0) begin
                held_left  = speed_pwm(longint'(cruise_reg) - pos);
                held_right = speed_pwm(longint'(cruise_reg) + pos);
                r.updated = 1'b1;
            end
            r.position = pos[POS_W-1:0];
            r.count    = cnt[CNT_W-1:0];
        end
        r.left_pwm  = held_left;
        r.right_pwm = held_right;
        return r;
    endfunction

    function automatic logic [SMP_W-1:0] clip_sample(input int v);
        if (v < 0) return '0;
        if (v > 1023) return 10'd1023;
        return v[SMP_W-1:0];
    endfunction

    function automatic t_frame pack_samples(input int s0, s1, s2, s3, s4, s5, s6, s7);
        int s [CHANNELS];
        t_frame f;
        s = '{s0, s1, s2, s3, s4, s5, s6, s7};
        for (int c = 0; c < CHANNELS; c++) f[c*SMP_W +: SMP_W] = clip_sample(s[c]);
        return f;
    endfunction

    function automatic t_frame rand_cal_frame(input int spread);
        t_frame f;
        for (int c = 0; c < CHANNELS; c++)
            f[c*SMP_W +: SMP_W] = clip_sample(512 - spread + int'($urandom_range(2 * spread - 1)));
        return f;
    endfunction

    // half plain noise, half a dark band around one channel against the learnt spans
    function automatic t_frame rand_track_frame();
        t_frame f;
        int centre, spread, lo, hi, v;
        bit shaped;
        shaped = 1'($urandom_range(1));
        centre = int'($urandom_range(CHANNELS - 1));
        spread = int'($urandom_range(2));
        for (int c = 0; c < CHANNELS; c++) begin
            lo = int'(cal_min[c]);
            hi = int'(cal_max[c]);
            if (!shaped || hi <= lo)
                v = int'($urandom_range(1023));
            else if ((c - centre <= spread) && (centre - c <= spread))
                v = lo - int'($urandom_range(40)) + int'($urandom_range((hi - lo) / 2));
            else
                v = hi + int'($urandom_range(40)) - int'($urandom_range((hi - lo) / 3));
            f[c*SMP_W +: SMP_W] = clip_sample(v);
        end
        return f;
    endfunction

    task automatic send_frame(input logic mode, input t_frame frame);
        t_drive_result want;
        if (tx_gaps && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 32);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        want = predict_drive(mode, frame);
        drive_expected.push_back(want);
        frames_sent++;
        if (mode == MODE_TRACK) track_frames++;
        if (want.updated) drive_updates++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CRUISE: cruise_reg = value;
            CFG_THRESH: thresh_reg = value[THR_W-1:0];
            CFG_GAIN:   gain_reg   = value[GAIN_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] cruise, thresh, gain);
        set_reg(CFG_CRUISE, cruise);
        set_reg(CFG_THRESH, thresh);
        set_reg(CFG_GAIN, gain);
        settings_used++;
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input logic [OUT_W-1:0] word);
        t_drive_result want;
        if (drive_expected.size() == 0) begin
            $display("%0t: result with nothing pending, expected none actual %h", $time, word);
            mismatches++;
        end else begin
            want = drive_expected.pop_front();
            compare_field("position", longint'($signed(want.position)),
                          longint'($signed(word[POS_W-1:0])));
            compare_field("sensed_count", longint'(want.count),
                          longint'(word[POS_W +: CNT_W]));
            compare_field("left_pwm", longint'(want.left_pwm),
                          longint'(word[POS_W+CNT_W +: PWM_W]));
            compare_field("right_pwm", longint'(want.right_pwm),
                          longint'(word[POS_W+CNT_W+PWM_W +: PWM_W]));
            compare_field("drive_updated", longint'(want.updated),
                          longint'(word[POS_W+CNT_W+2*PWM_W]));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_axis_tready <= !(rx_gaps && $urandom_range(99) < 32);
            end
        end
    end

    task automatic test_empty_spans();
        send_frame(MODE_TRACK, rand_track_frame());
        // threshold written with junk above bit 6, which must be dropped
        set_reg(CFG_THRESH, 16'hFF80);
        send_frame(MODE_TRACK, pack_samples(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
        set_reg(CFG_THRESH, 16'd60);
    endtask

    task automatic test_calibration();
        send_frame(MODE_CAL, pack_samples(1023, 600, 600, 600, 600, 600, 600, 1023));
        send_frame(MODE_CAL, pack_samples(1022, 400, 400, 600, 400, 400, 400, 1022));
    endtask

    task automatic test_track_extremes();
        send_frame(MODE_TRACK, pack_samples(0, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
        send_frame(MODE_TRACK, pack_samples(1023, 1023, 1023, 1023, 1023, 1023, 1023, 0));
        send_frame(MODE_TRACK, pack_samples(0, 1023, 1023, 1023, 1023, 1023, 1023, 0));
        send_frame(MODE_TRACK, pack_samples(0, 0, 0, 0, 0, 0, 0, 0));
        send_frame(MODE_TRACK, pack_samples(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
        send_frame(MODE_TRACK, pack_samples(1023, 480, 481, 1023, 1023, 1023, 1023, 1023));
        send_frame(MODE_TRACK, pack_samples(1023, 1023, 1023, 1023, 1023, 480, 478, 1023));
        send_frame(MODE_CAL, pack_samples(1022, 500, 500, 600, 500, 500, 500, 1022));
    endtask

    task automatic test_register_extremes();
        program_regs(16'd0, 16'd60, 16'hFF7F);
        send_frame(MODE_TRACK, pack_samples(1023, 1023, 1023, 1023, 1023, 1023, 478, 1023));
        program_regs(16'hFFFF, 16'd60, 16'd100);
        send_frame(MODE_TRACK, pack_samples(1023, 480, 1023, 1023, 1023, 1023, 1023, 1023));
        program_regs(16'd4000, 16'd127, 16'd0);
        send_frame(MODE_TRACK, pack_samples(1023, 0, 1023, 1023, 1023, 1023, 1023, 1023));
        program_regs(16'd4000, 16'd100, 16'd18);
        send_frame(MODE_TRACK, pack_samples(1023, 1023, 400, 1023, 1023, 1023, 1023, 1023));
        // unmapped index: settings must stay as they are
        set_reg(CFG_SPARE, 16'h0000);
        send_frame(MODE_TRACK, pack_samples(1023, 1023, 400, 1023, 1023, 1023, 1023, 1023));
    endtask

    task automatic test_random_sweep();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: program_regs(16'd4000, 16'd60, 16'd18);
                1: program_regs(16'd0, 16'd0, 16'd100);
                2: program_regs(16'hFFFF, 16'd100, 16'd127);
                3: program_regs(CFG_DATA_W'($urandom_range(65535)), 16'd30, 16'd50);
                4: program_regs(16'd1000, 16'd127, 16'd0);
                7: program_regs(16'd32768, 16'd80, 16'd100);
                default: program_regs(CFG_DATA_W'($urandom_range(65535)),
                                      CFG_DATA_W'($urandom_range(100)),
                                      CFG_DATA_W'($urandom_range(100)));
            endcase
            tx_gaps = (phase != 3);
            rx_gaps = (phase != 3);
            for (int n = 0; n < 190; n++) begin
                if ($urandom_range(99) < 15)
                    send_frame(MODE_CAL, rand_cal_frame(60 + 55 * phase));
                else
                    send_frame(MODE_TRACK, rand_track_frame());
            end
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_output_stall();
        wait_idle();
        rx_hold_cycles = 3000;
        for (int n = 0; n < 8; n++) send_frame(MODE_TRACK, rand_track_frame());
    endtask

    initial begin
        cruise_reg = CRUISE_RST;
        thresh_reg = THR_RST;
        gain_reg   = GAIN_RST;
        held_left  = '0;
        held_right = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            cal_max[c] = '0;
            cal_min[c] = 10'd1023;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_spans();
        test_calibration();
        test_track_extremes();
        test_register_extremes();
        test_random_sweep();
        test_output_stall();

        wait_idle();
        repeat (400) @(posedge i_clk);
        $display("Covered %0d frames (%0d tracking, %0d drive updates) over %0d settings,",
                 frames_sent, track_frames, drive_updates, settings_used);
        $display("including empty spans, saturated PWM, unmapped writes and a long output stall.");
        if (mismatches == 0)
            $display("tb_line_sensor_position_drive passed");
        else
            $display("tb_line_sensor_position_drive failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timeout with %0d results outstanding", drive_expected.size());
        $display("tb_line_sensor_position_drive failed");
        $finish;
    end

endmodule
